[design/cwt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cwt_pkg;

  localparam int CAP    = 64;
  localparam int SLOT_W = $clog2(CAP);
  localparam int CNT_W  = $clog2(CAP + 1);

  // port field widths
  localparam int OP_FW   = 4;
  localparam int FAC_FW  = 8;
  localparam int NUM_FW  = 16;
  localparam int SLOT_FW = 6;
  localparam int ACC_FW  = 8;
  localparam int ST_FW   = 3;
  localparam int CNT_FW  = 7;

  typedef enum logic [OP_FW-1:0] {
    OP_FIND    = 4'd0,
    OP_GET     = 4'd1,
    OP_ADD     = 4'd2,
    OP_UPDATE  = 4'd3,
    OP_REMOVE  = 4'd4,
    OP_CLEAR   = 4'd5,
    OP_ARM     = 4'd6,
    OP_CANCEL  = 4'd7,
    OP_CAPTURE = 4'd8
  } op_t;

  typedef enum logic [ST_FW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_NOT_ARMED = 3'd5
  } status_t;

  typedef struct packed {
    logic [FAC_FW-1:0] fac;
    logic [NUM_FW-1:0] num;
    logic [ACC_FW-1:0] acc;
    logic              act;
  } ent_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [ACC_FW-1:0] acc;
    logic              act;
  } tok_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic [FAC_FW-1:0] key_fac;
    logic [NUM_FW-1:0] key_num;
    logic [SLOT_W-1:0] get_slot;
    logic [CNT_W-1:0]  count;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    ent_t              wr_ent;
    logic              sh_en;
    logic [SLOT_W-1:0] sh_slot;
  } cmd_t;

endpackage

`default_nettype wire

[design/cwt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module cwt_cell
  import cwt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] cell_idx,
  input  wire cmd_t              cmd,
  input  wire tok_t              tok_in,
  input  wire ent_t              nb_ent,
  output tok_t                   tok_out,
  output ent_t                   ent_out
);

  ent_t ent_r;
  tok_t tok_r;
  tok_t tok_nxt;
  logic in_range;
  logic match;

  assign in_range = CNT_W'(cell_idx) < cmd.count;
  assign match    = in_range && (ent_r.fac == cmd.key_fac) && (ent_r.num == cmd.key_num);

  always_comb begin
    tok_nxt = tok_in;
    // first match wins, later cells pass it on
    if (tok_in.vld && !tok_in.found && match) begin
      tok_nxt.found = 1'b1;
      tok_nxt.slot  = cell_idx;
    end
    if (tok_in.vld && (cell_idx == cmd.get_slot)) begin
      tok_nxt.acc = ent_r.acc;
      tok_nxt.act = ent_r.act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  // entry storage: direct write or shift down from the upper neighbor
  always_ff @(posedge clk) begin
    if (cmd.wr_en && (cell_idx == cmd.wr_slot)) begin
      ent_r <= cmd.wr_ent;
    end else if (cmd.sh_en && (cell_idx >= cmd.sh_slot)) begin
      ent_r <= nb_ent;
    end
  end

  assign tok_out = tok_r;
  assign ent_out = ent_r;

endmodule

`default_nettype wire

[design/card_whitelist_table_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | ports                                             | flow
// ---------+---------------------------------------------------+------------------------
// input    | in_valid in_stall in_op .. in_active_flag         | one word per operation
// result   | out_valid out_stall out_status .. out_learn_armed | one word per input word
// config   | cfg_we cfg_permanent_access_code                  | write only, no wait
//
// each word goes through these steps in order: a search token walks the row of CAP
// cells, one cell per cycle, the search result is latched, a commit writes or shifts
// the row, and the next word is taken in the cycle after the commit.
// reset clears the entry count, learn mode and the token chain; entries are
// not cleared and are only read below the count. a stalled result holds the
// commit, a result register lets the next word in while it waits.

module card_whitelist_table_core
  import cwt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [OP_FW-1:0]   in_op,
  input  wire logic [FAC_FW-1:0]  in_facility,
  input  wire logic [NUM_FW-1:0]  in_card_number,
  input  wire logic [SLOT_FW-1:0] in_slot_index,
  input  wire logic [ACC_FW-1:0]  in_access_code,
  input  wire logic               in_active_flag,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ST_FW-1:0]        out_status,
  output logic                    out_hit,
  output logic [SLOT_FW-1:0]      out_found_slot,
  output logic [ACC_FW-1:0]       out_found_access,
  output logic                    out_found_active,
  output logic [CNT_FW-1:0]       out_entry_count,
  output logic                    out_learn_armed,
  input  wire logic               cfg_we,
  input  wire logic [ACC_FW-1:0]  cfg_permanent_access_code
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r;
  logic   start_r;
  logic   out_valid_r;
  logic [ACC_FW-1:0] perm_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              armed_r;
  logic              armed_nxt;

  // held word
  logic [OP_FW-1:0]   op_r;
  logic [FAC_FW-1:0]  fac_r;
  logic [NUM_FW-1:0]  num_r;
  logic [SLOT_FW-1:0] sidx_r;
  logic [ACC_FW-1:0]  acc_r;
  logic               act_r;

  // search result
  logic              sf_found_r;
  logic [SLOT_W-1:0] sf_slot_r;
  logic [ACC_FW-1:0] sf_acc_r;
  logic              sf_act_r;

  // result registers
  logic [ST_FW-1:0]   o_status_r;
  logic               o_hit_r;
  logic [SLOT_FW-1:0] o_slot_r;
  logic [ACC_FW-1:0]  o_acc_r;
  logic               o_act_r;
  logic [CNT_FW-1:0]  o_cnt_r;
  logic               o_armed_r;

  status_t            status_c;
  logic               hit_c;
  logic [SLOT_FW-1:0] slot_c;
  logic [ACC_FW-1:0]  facc_c;
  logic               fact_c;

  cmd_t cmd;
  tok_t tok_w [CAP+1];
  ent_t ent_w [CAP];
  logic [CAP-1:0] tok_vld;

  logic in_acc;
  logic out_free;
  logic commit;
  logic full;
  logic get_ok;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign commit   = (state_r == S_DONE) && out_free;
  assign full     = (32'(cnt_r) >= CAP);
  assign get_ok   = (32'(sidx_r) < 32'(cnt_r));

  assign tok_w[0] = '{vld: start_r, found: 1'b0, slot: '0, acc: '0, act: 1'b0};

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    cwt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(i)),
      .cmd      (cmd),
      .tok_in   (tok_w[i]),
      .nb_ent   ((i == CAP - 1) ? ent_w[i] : ent_w[(i + 1) % CAP]),
      .tok_out  (tok_w[i+1]),
      .ent_out  (ent_w[i])
    );
    assign tok_vld[i] = tok_w[i+1].vld;
  end

  // decide result and table change for the held word
  always_comb begin
    status_c       = ST_OK;
    hit_c          = 1'b0;
    slot_c         = '0;
    facc_c         = '0;
    fact_c         = 1'b0;
    cnt_nxt        = cnt_r;
    armed_nxt      = armed_r;
    cmd.key_fac    = fac_r;
    cmd.key_num    = num_r;
    cmd.get_slot   = SLOT_W'(sidx_r);
    cmd.count      = cnt_r;
    cmd.wr_en      = 1'b0;
    cmd.wr_slot    = SLOT_W'(cnt_r);
    cmd.wr_ent     = '{fac: fac_r, num: num_r, acc: acc_r, act: act_r};
    cmd.sh_en      = 1'b0;
    cmd.sh_slot    = sf_slot_r;
    case (op_t'(op_r))
      OP_FIND: begin
        if (sf_found_r) begin
          hit_c  = 1'b1;
          slot_c = SLOT_FW'(sf_slot_r);
        end else begin
          status_c = ST_NOT_FOUND;
        end
      end
      OP_GET: begin
        if (get_ok) begin
          hit_c  = 1'b1;
          slot_c = sidx_r;
          facc_c = sf_acc_r;
          fact_c = sf_act_r;
        end else begin
          status_c = ST_BAD_INDEX;
        end
      end
      OP_ADD: begin
        if (full) begin
          status_c = ST_FULL;
        end else if (sf_found_r) begin
          status_c = ST_DUPLICATE;
          hit_c    = 1'b1;
          slot_c   = SLOT_FW'(sf_slot_r);
        end else begin
          cmd.wr_en = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      OP_UPDATE: begin
        if (sf_found_r) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_slot = sf_slot_r;
          hit_c       = 1'b1;
          slot_c      = SLOT_FW'(sf_slot_r);
        end else begin
          status_c = ST_NOT_FOUND;
        end
      end
      OP_REMOVE: begin
        if (sf_found_r) begin
          cmd.sh_en = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
          hit_c     = 1'b1;
          slot_c    = SLOT_FW'(sf_slot_r);
        end else begin
          status_c = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      OP_ARM: begin
        armed_nxt = 1'b1;
      end
      OP_CANCEL: begin
        armed_nxt = 1'b0;
      end
      OP_CAPTURE: begin
        cmd.wr_ent = '{fac: fac_r, num: num_r, acc: perm_r, act: 1'b1};
        if (!armed_r) begin
          status_c = ST_NOT_ARMED;
        end else begin
          armed_nxt = 1'b0;
          if (sf_found_r) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_slot = sf_slot_r;
            hit_c       = 1'b1;
            slot_c      = SLOT_FW'(sf_slot_r);
          end else if (full) begin
            status_c = ST_FULL;
          end else begin
            cmd.wr_en = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (!commit) begin
      cmd.wr_en = 1'b0;
      cmd.sh_en = 1'b0;
      cnt_nxt   = cnt_r;
      armed_nxt = armed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      armed_r     <= 1'b0;
      perm_r      <= '0;
    end else begin
      start_r <= in_acc;
      cnt_r   <= cnt_nxt;
      armed_r <= armed_nxt;
      if (cfg_we) begin
        perm_r <= cfg_permanent_access_code;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_w[CAP].vld) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      fac_r  <= in_facility;
      num_r  <= in_card_number;
      sidx_r <= in_slot_index;
      acc_r  <= in_access_code;
      act_r  <= in_active_flag;
    end
    if (tok_w[CAP].vld) begin
      sf_found_r <= tok_w[CAP].found;
      sf_slot_r  <= tok_w[CAP].slot;
      sf_acc_r   <= tok_w[CAP].acc;
      sf_act_r   <= tok_w[CAP].act;
    end
    if (commit) begin
      o_status_r <= status_c;
      o_hit_r    <= hit_c;
      o_slot_r   <= slot_c;
      o_acc_r    <= facc_c;
      o_act_r    <= fact_c;
      o_cnt_r    <= CNT_FW'(cnt_nxt);
      o_armed_r  <= armed_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = o_status_r;
  assign out_hit          = o_hit_r;
  assign out_found_slot   = o_slot_r;
  assign out_found_access = o_acc_r;
  assign out_found_active = o_act_r;
  assign out_entry_count  = o_cnt_r;
  assign out_learn_armed  = o_armed_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAP)
    else $error("entry count above capacity");

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one search token in the row");

  a_token_end: assert property (@(posedge clk) disable iff (!rst_n)
    tok_w[CAP].vld |-> state_r == S_SCAN)
    else $error("search token left the row outside a scan");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> cnt_r == $past(cnt_r))
    else $error("entry count changed without a commit");
`endif

endmodule

`default_nettype wire

[verif/card_whitelist_table_core_test.sv]
`timescale 1ns / 1ps

module card_whitelist_table_core_test;
  import cwt_pkg::*;

  localparam logic [OP_FW-1:0] OP_SPARE_LO = 4'd9;
  localparam logic [OP_FW-1:0] OP_SPARE_HI = 4'd15;
  localparam int RAND_WORDS = 270;
  localparam int PHASES     = 6;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_LONG} rx_mode_t;

  typedef struct packed {
    logic [OP_FW-1:0]   op;
    logic [FAC_FW-1:0]  fac;
    logic [NUM_FW-1:0]  num;
    logic [SLOT_FW-1:0] slot;
    logic [ACC_FW-1:0]  acc;
    logic               act;
  } card_word_t;

  typedef struct packed {
    status_t            status;
    logic               hit;
    logic [SLOT_FW-1:0] slot;
    logic [ACC_FW-1:0]  acc;
    logic               act;
    logic [CNT_FW-1:0]  count;
    logic               armed;
  } card_reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_FW-1:0]   in_op = '0;
  logic [FAC_FW-1:0]  in_facility = '0;
  logic [NUM_FW-1:0]  in_card_number = '0;
  logic [SLOT_FW-1:0] in_slot_index = '0;
  logic [ACC_FW-1:0]  in_access_code = '0;
  logic               in_active_flag = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ST_FW-1:0]   out_status;
  logic               out_hit;
  logic [SLOT_FW-1:0] out_found_slot;
  logic [ACC_FW-1:0]  out_found_access;
  logic               out_found_active;
  logic [CNT_FW-1:0]  out_entry_count;
  logic               out_learn_armed;
  logic               cfg_we = 1'b0;
  logic [ACC_FW-1:0]  cfg_permanent_access_code = '0;

  // predictor state
  ent_t              roster[CAP];
  int                roster_len = 0;
  logic              arm_state = 1'b0;
  logic [ACC_FW-1:0] perm_code = '0;

  card_word_t  pending_words[$];
  card_reply_t due_replies[$];
  card_reply_t exp_reply;

  logic [FAC_FW-1:0] pool_fac[$];
  logic [NUM_FW-1:0] pool_num[$];

  int errors = 0;
  int words_in = 0;
  int replies_seen = 0;
  int peak_fill = 0;
  int status_seen[8];

  int         burst_left = 0;
  int         gap_left = 0;
  logic       in_took = 1'b0;
  card_word_t drv_word;

  rx_mode_t rx_mode = RX_FREE;
  int       mode_left = 0;
  int       hold_left = 0;

  card_whitelist_table_core u_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_op                     (in_op),
    .in_facility               (in_facility),
    .in_card_number            (in_card_number),
    .in_slot_index             (in_slot_index),
    .in_access_code            (in_access_code),
    .in_active_flag            (in_active_flag),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_status                (out_status),
    .out_hit                   (out_hit),
    .out_found_slot            (out_found_slot),
    .out_found_access          (out_found_access),
    .out_found_active          (out_found_active),
    .out_entry_count           (out_entry_count),
    .out_learn_armed           (out_learn_armed),
    .cfg_we                    (cfg_we),
    .cfg_permanent_access_code (cfg_permanent_access_code)
  );

  always #4 clk = ~clk;

  function automatic int find_key(logic [FAC_FW-1:0] fac, logic [NUM_FW-1:0] num);
    for (int i = 0; i < roster_len; i++) begin
      if (roster[i].fac == fac && roster[i].num == num) return i;
    end
    return -1;
  endfunction

  // applies one word to the table copy and returns the reply it should give
  function automatic card_reply_t apply_card_op(card_word_t w);
    card_reply_t r;
    int k;
    r = '0;
    r.status = ST_OK;
    k = find_key(w.fac, w.num);
    case (w.op)
      OP_FIND: begin
        if (k >= 0) begin
          r.hit = 1'b1;
          r.slot = SLOT_FW'(k);
        end else r.status = ST_NOT_FOUND;
      end
      OP_GET: begin
        if (int'(w.slot) < roster_len) begin
          r.hit = 1'b1;
          r.slot = w.slot;
          r.acc = roster[w.slot].acc;
          r.act = roster[w.slot].act;
        end else r.status = ST_BAD_INDEX;
      end
      OP_ADD: begin
        // full is checked before duplicate
        if (roster_len >= CAP) r.status = ST_FULL;
        else if (k >= 0) begin
          r.status = ST_DUPLICATE;
          r.hit = 1'b1;
          r.slot = SLOT_FW'(k);
        end else begin
          roster[roster_len] = {w.fac, w.num, w.acc, w.act};
          roster_len++;
        end
      end
      OP_UPDATE: begin
        if (k >= 0) begin
          roster[k] = {w.fac, w.num, w.acc, w.act};
          r.hit = 1'b1;
          r.slot = SLOT_FW'(k);
        end else r.status = ST_NOT_FOUND;
      end
      OP_REMOVE: begin
        if (k >= 0) begin
          r.hit = 1'b1;
          r.slot = SLOT_FW'(k);
          for (int i = k; i < roster_len - 1; i++) roster[i] = roster[i + 1];
          roster[roster_len - 1] = '0;
          roster_len--;
        end else r.status = ST_NOT_FOUND;
      end
      OP_CLEAR: roster_len = 0;
      OP_ARM: arm_state = 1'b1;
      OP_CANCEL: arm_state = 1'b0;
      OP_CAPTURE: begin
        if (!arm_state) r.status = ST_NOT_ARMED;
        else begin
          if (k >= 0) begin
            roster[k] = {w.fac, w.num, perm_code, 1'b1};
            r.hit = 1'b1;
            r.slot = SLOT_FW'(k);
          end else if (roster_len >= CAP) r.status = ST_FULL;
          else begin
            roster[roster_len] = {w.fac, w.num, perm_code, 1'b1};
            roster_len++;
          end
          // learn mode drops even when the table had no room
          arm_state = 1'b0;
        end
      end
      default: ;
    endcase
    r.count = CNT_FW'(roster_len);
    r.armed = arm_state;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("[%0t] mismatch on result %0d: %s", $time, replies_seen, msg);
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic queue_word(logic [OP_FW-1:0] op, logic [FAC_FW-1:0] fac,
                            logic [NUM_FW-1:0] num, logic [SLOT_FW-1:0] slot,
                            logic [ACC_FW-1:0] acc, logic act);
    pending_words.push_back(card_word_t'({op, fac, num, slot, acc, act}));
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || due_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_perm_code(logic [ACC_FW-1:0] code);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_permanent_access_code <= code;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender: bursts of words separated by random gaps
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() != 0) begin
        drv_word = pending_words.pop_front();
        in_op <= drv_word.op;
        in_facility <= drv_word.fac;
        in_card_number <= drv_word.num;
        in_slot_index <= drv_word.slot;
        in_access_code <= drv_word.acc;
        in_active_flag <= drv_word.act;
        in_valid <= 1'b1;
        if (burst_left > 1) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(2) == 0) ? $urandom_range(100, 1) : 0;
        end
      end else in_valid <= 1'b0;
    end
  end

  // receiver: free-running, choppy or long stall runs, switching now and then
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(2));
      mode_left <= $urandom_range(2000, 200);
    end else mode_left <= mode_left - 1;
    case (rx_mode)
      RX_FREE: out_stall <= 1'b0;
      RX_CHOPPY: out_stall <= ($urandom_range(9) < 3);
      default: begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        else begin
          out_stall <= !out_stall;
          hold_left <= $urandom_range(60);
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      roster_len = 0;
      arm_state = 1'b0;
      perm_code = '0;
      in_took <= 1'b0;
    end else begin
      if (cfg_we) perm_code = cfg_permanent_access_code;
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (due_replies.size() == 0) report_mismatch("result word with nothing pending");
        else begin
          exp_reply = due_replies.pop_front();
          compare_field("status", 16'(out_status), 16'(exp_reply.status));
          compare_field("hit", 16'(out_hit), 16'(exp_reply.hit));
          compare_field("found_slot", 16'(out_found_slot), 16'(exp_reply.slot));
          compare_field("found_access", 16'(out_found_access), 16'(exp_reply.acc));
          compare_field("found_active", 16'(out_found_active), 16'(exp_reply.act));
          compare_field("entry_count", 16'(out_entry_count), 16'(exp_reply.count));
          compare_field("learn_armed", 16'(out_learn_armed), 16'(exp_reply.armed));
          status_seen[exp_reply.status]++;
        end
      end
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        due_replies.push_back(apply_card_op(card_word_t'({in_op, in_facility, in_card_number,
            in_slot_index, in_access_code, in_active_flag})));
        words_in++;
        if (roster_len > peak_fill) peak_fill = roster_len;
      end
    end
  end

  initial begin
    #16_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int phase, n, i, k, pick;
    logic [ACC_FW-1:0] perm_vals[PHASES];
    card_word_t w;

    for (i = 0; i < 8; i++) status_seen[i] = 0;
    perm_vals[0] = 8'hFF;
    perm_vals[1] = 8'h00;
    perm_vals[2] = ACC_FW'($urandom);
    perm_vals[3] = 8'h01;
    perm_vals[4] = ACC_FW'($urandom);
    perm_vals[5] = 8'h7F;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    write_perm_code(8'hA5);

    // empty table, key extremes, learn mode paths, removal with shift
    queue_word(OP_GET, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_FIND, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_CAPTURE, 8'h12, 16'h3456, 6'd0, 8'h00, 1'b0);
    queue_word(OP_ADD, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_ADD, 8'hFF, 16'hFFFF, 6'd63, 8'hFF, 1'b1);
    queue_word(OP_ADD, 8'h00, 16'h0000, 6'd0, 8'h33, 1'b1);
    queue_word(OP_FIND, 8'hFF, 16'hFFFF, 6'd0, 8'h00, 1'b0);
    queue_word(OP_GET, 8'h00, 16'h0000, 6'd1, 8'h00, 1'b0);
    queue_word(OP_GET, 8'h00, 16'h0000, 6'd63, 8'h00, 1'b0);
    queue_word(OP_UPDATE, 8'h00, 16'h0000, 6'd0, 8'h5A, 1'b1);
    queue_word(OP_UPDATE, 8'h01, 16'h0001, 6'd0, 8'h5A, 1'b1);
    queue_word(OP_ARM, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_CAPTURE, 8'h12, 16'h3456, 6'd0, 8'h00, 1'b0);
    queue_word(OP_CAPTURE, 8'h12, 16'h3456, 6'd0, 8'h00, 1'b0);
    queue_word(OP_ARM, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_CANCEL, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_CAPTURE, 8'hFF, 16'hFFFF, 6'd0, 8'h00, 1'b0);
    queue_word(OP_ARM, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_CAPTURE, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_GET, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_REMOVE, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_GET, 8'h00, 16'h0000, 6'd1, 8'h00, 1'b0);
    queue_word(OP_REMOVE, 8'h01, 16'h0001, 6'd0, 8'h00, 1'b0);
    queue_word(OP_SPARE_LO, 8'hFF, 16'hFFFF, 6'd63, 8'hFF, 1'b1);
    queue_word(OP_SPARE_HI, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_CLEAR, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
    queue_word(OP_GET, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      write_perm_code(perm_vals[phase]);
      pool_fac.delete();
      pool_num.delete();
      if (phase == 1 || phase == 4) begin
        // fill every slot, then poke the full table from all sides
        queue_word(OP_CLEAR, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
        for (i = 0; i < CAP; i++) begin
          pool_fac.push_back(FAC_FW'(i));
          pool_num.push_back(NUM_FW'($urandom));
          queue_word(OP_ADD, pool_fac[i], pool_num[i], '0, ACC_FW'($urandom), 1'($urandom));
        end
        queue_word(OP_ADD, 8'hFF, NUM_FW'($urandom), '0, 8'h11, 1'b1);
        queue_word(OP_ADD, pool_fac[7], pool_num[7], '0, 8'h22, 1'b0);
        queue_word(OP_ARM, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
        queue_word(OP_CAPTURE, 8'hFE, NUM_FW'($urandom), '0, 8'h00, 1'b0);
        queue_word(OP_CAPTURE, pool_fac[3], pool_num[3], '0, 8'h00, 1'b0);
        queue_word(OP_ARM, 8'h00, 16'h0000, 6'd0, 8'h00, 1'b0);
        queue_word(OP_CAPTURE, pool_fac[CAP-1], pool_num[CAP-1], '0, 8'h00, 1'b0);
        queue_word(OP_GET, 8'h00, 16'h0000, 6'd63, 8'h00, 1'b0);
        queue_word(OP_REMOVE, pool_fac[0], pool_num[0], '0, 8'h00, 1'b0);
        queue_word(OP_GET, 8'h00, 16'h0000, 6'd62, 8'h00, 1'b0);
        queue_word(OP_GET, 8'h00, 16'h0000, 6'd63, 8'h00, 1'b0);
        k = 16;
      end else k = (phase % 2 == 0) ? 80 : 12;
      for (i = 0; i < k; i++) begin
        pool_fac.push_back(FAC_FW'($urandom));
        pool_num.push_back(NUM_FW'($urandom));
      end
      pool_fac.push_back('0);
      pool_num.push_back('0);
      pool_fac.push_back('1);
      pool_num.push_back('1);

      n = 0;
      while (n < RAND_WORDS) begin
        k = $urandom_range(pool_fac.size() - 1);
        w.fac = pool_fac[k];
        w.num = pool_num[k];
        if ($urandom_range(19) == 0) begin
          w.fac = FAC_FW'($urandom);
          w.num = NUM_FW'($urandom);
        end
        w.slot = ($urandom_range(1) == 0) ? SLOT_FW'($urandom_range(15))
                                          : SLOT_FW'($urandom_range(CAP - 1));
        w.acc = ACC_FW'($urandom);
        w.act = 1'($urandom);
        pick = $urandom_range(999);
        if (pick < 150) w.op = OP_FIND;
        else if (pick < 300) w.op = OP_GET;
        else if (pick < 540) w.op = OP_ADD;
        else if (pick < 640) w.op = OP_UPDATE;
        else if (pick < 740) w.op = OP_REMOVE;
        else if (pick < 743) w.op = OP_CLEAR;
        else if (pick < 810) w.op = OP_ARM;
        else if (pick < 830) w.op = OP_CANCEL;
        else if (pick < 980) w.op = OP_CAPTURE;
        else w.op = OP_FW'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
        // most captures come right after an arm
        if (w.op == OP_CAPTURE && $urandom_range(2) != 0) begin
          queue_word(OP_ARM, FAC_FW'($urandom), NUM_FW'($urandom), SLOT_FW'($urandom),
                     ACC_FW'($urandom), 1'($urandom));
          n++;
        end
        pending_words.push_back(w);
        n++;
      end
    end

    wait_idle();
    repeat (CAP * 2) @(posedge clk);
    $display("%0d words sent, %0d results checked, table peaked at %0d of %0d entries",
             words_in, replies_seen, peak_fill, CAP);
    $display("statuses: ok %0d, not found %0d, bad index %0d, full %0d, dup %0d, not armed %0d",
             status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_BAD_INDEX],
             status_seen[ST_FULL], status_seen[ST_DUPLICATE], status_seen[ST_NOT_ARMED]);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[card_whitelist_table_core.f]
design/cwt_pkg.sv
design/cwt_cell.sv
design/card_whitelist_table_core.sv
verif/card_whitelist_table_core_test.sv
